FILE: rtl/dqr_pkg.sv
// shared types, constants and name table for the dns query responder
package dqr_pkg;

   // longest datagram tracked; later bytes are ignored
   localparam int MAX_DATAGRAM = 64;
   localparam int POS_W        = $clog2(MAX_DATAGRAM + 1);

   localparam int HDR_LEN   = 12;
   localparam int QNAME_LEN = 14;
   localparam int TC_LEN    = 4;
   localparam int REPLY_LEN = 46;
   localparam int RPOS_W    = $clog2(REPLY_LEN);

   // configuration register indexes
   localparam logic CSR_REPLY_ADDRESS = 1'b0;
   localparam logic CSR_REPLY_TTL     = 1'b1;

   localparam logic [31:0] REPLY_ADDRESS_RESET = 32'hC0A8_0A01;
   localparam logic [31:0] REPLY_TTL_RESET     = 32'h0000_0001;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_NAME,
      PH_TYPECLASS,
      PH_IGNORE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_datagram;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_reply;
   } rsp_type;

   typedef logic [HDR_LEN-1:0][7:0] hdr_bytes_type;
   typedef logic [TC_LEN-1:0][7:0]  tc_bytes_type;

   // expected question name in wire form: length-prefixed labels, root terminator
   function automatic logic [7:0] wire_name_byte(input logic [3:0] k);
      logic [7:0] b;
      begin
         case (k)
            4'd0:    b = 8'h06;
            4'd1:    b = 8'h7A;
            4'd2:    b = 8'h65;
            4'd3:    b = 8'h70;
            4'd4:    b = 8'h68;
            4'd5:    b = 8'h79;
            4'd6:    b = 8'h72;
            4'd7:    b = 8'h05;
            4'd8:    b = 8'h6C;
            4'd9:    b = 8'h6F;
            4'd10:   b = 8'h63;
            4'd11:   b = 8'h61;
            4'd12:   b = 8'h6C;
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

endpackage

FILE: rtl/dqr_parser.sv
// request parser: header capture, name match, type and class capture
module dqr_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  dqr_pkg::req_type      req_data,
   output dqr_pkg::hdr_bytes_type hdr_bytes,
   output dqr_pkg::tc_bytes_type tc_bytes,
   output logic                  start
);

   dqr_pkg::phase_type           phase_ff, phase_in;
   logic [dqr_pkg::POS_W-1:0]    pos_ff, pos_in;
   dqr_pkg::hdr_bytes_type       hdr_ff;
   dqr_pkg::tc_bytes_type        tc_ff;

   logic                         in_range;
   logic [dqr_pkg::POS_W-1:0]    name_off;
   logic [dqr_pkg::POS_W-1:0]    tc_off;
   logic [3:0]                   name_k;
   logic [1:0]                   tc_k;
   logic                         hdr_ok;
   logic                         hdr_we;
   logic                         tc_we;

   assign in_range = (pos_ff < dqr_pkg::POS_W'(dqr_pkg::MAX_DATAGRAM));
   assign name_off = pos_ff - dqr_pkg::POS_W'(dqr_pkg::HDR_LEN);
   assign tc_off   = pos_ff - dqr_pkg::POS_W'(dqr_pkg::HDR_LEN + dqr_pkg::QNAME_LEN);
   assign name_k   = name_off[3:0];
   assign tc_k     = tc_off[1:0];
   // qr clear and a nonzero question count
   assign hdr_ok   = !hdr_ff[2][7] && ((hdr_ff[4] | hdr_ff[5]) != 8'h00);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && in_range) begin
         unique case (phase_ff)
            dqr_pkg::PH_HEADER: begin
               if (pos_ff == dqr_pkg::POS_W'(dqr_pkg::HDR_LEN - 1)) begin
                  phase_in = hdr_ok ? dqr_pkg::PH_NAME : dqr_pkg::PH_IGNORE;
               end
            end
            dqr_pkg::PH_NAME: begin
               if (name_off >= dqr_pkg::POS_W'(dqr_pkg::QNAME_LEN) ||
                   req_data.data_byte != dqr_pkg::wire_name_byte(name_k)) begin
                  phase_in = dqr_pkg::PH_IGNORE;
               end else if (name_k == 4'(dqr_pkg::QNAME_LEN - 1)) begin
                  phase_in = dqr_pkg::PH_TYPECLASS;
               end
            end
            dqr_pkg::PH_TYPECLASS: begin
               if (tc_off >= dqr_pkg::POS_W'(dqr_pkg::TC_LEN) || tc_k == 2'd3) begin
                  phase_in = dqr_pkg::PH_IGNORE;
               end
            end
            dqr_pkg::PH_IGNORE: begin
               phase_in = dqr_pkg::PH_IGNORE;
            end
            default: begin
               phase_in = dqr_pkg::PH_IGNORE;
            end
         endcase
      end
      if (accept && req_data.last_of_datagram) begin
         phase_in = dqr_pkg::PH_HEADER;
      end
   end

   // phase outputs
   always_comb begin
      hdr_we = 1'b0;
      tc_we  = 1'b0;
      start  = 1'b0;
      if (accept && in_range) begin
         unique case (phase_ff) inside
            dqr_pkg::PH_HEADER: begin
               hdr_we = (pos_ff < dqr_pkg::POS_W'(dqr_pkg::HDR_LEN));
            end
            dqr_pkg::PH_TYPECLASS: begin
               tc_we = (tc_off < dqr_pkg::POS_W'(dqr_pkg::TC_LEN));
               start = tc_we && (tc_k == 2'd3);
            end
            dqr_pkg::PH_NAME, dqr_pkg::PH_IGNORE: begin
               hdr_we = 1'b0;
            end
            default: begin
               hdr_we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_data.last_of_datagram) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dqr_pkg::PH_HEADER;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[pos_ff[3:0]] <= req_data.data_byte;
      end
      if (tc_we) begin
         tc_ff[tc_k] <= req_data.data_byte;
      end
   end

   assign hdr_bytes = hdr_ff;
   assign tc_bytes  = tc_ff;

endmodule

FILE: rtl/dqr_reply_gen.sv
// reply generator: walks the 46 reply bytes into an output register
module dqr_reply_gen (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  dqr_pkg::hdr_bytes_type hdr_bytes,
   input  dqr_pkg::tc_bytes_type  tc_bytes,
   input  logic [31:0]            reply_ttl,
   input  logic [31:0]            reply_address,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output dqr_pkg::rsp_type       rsp_data,
   output logic                   busy
);

   logic                       busy_ff, busy_in;
   logic [dqr_pkg::RPOS_W-1:0] rpos_ff, rpos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   dqr_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                       load;
   logic                       at_end;
   logic [dqr_pkg::RPOS_W-1:0] name_off;
   logic [dqr_pkg::RPOS_W-1:0] tc_off;
   logic [dqr_pkg::RPOS_W-1:0] ttl_off;
   logic [dqr_pkg::RPOS_W-1:0] addr_off;
   logic [7:0]                 byte_sel;

   assign load   = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_end = (rpos_ff == dqr_pkg::RPOS_W'(dqr_pkg::REPLY_LEN - 1));

   assign name_off = rpos_ff - dqr_pkg::RPOS_W'(12);
   assign tc_off   = rpos_ff - dqr_pkg::RPOS_W'(26);
   assign ttl_off  = rpos_ff - dqr_pkg::RPOS_W'(36);
   assign addr_off = rpos_ff - dqr_pkg::RPOS_W'(42);

   // reply byte decoder
   always_comb begin
      unique case (rpos_ff) inside
         6'd0, 6'd1, [6'd3:6'd5], [6'd8:6'd11]:
                         byte_sel = hdr_bytes[rpos_ff[3:0]];
         6'd2:           byte_sel = hdr_bytes[2] | 8'h80;
         6'd6:           byte_sel = 8'h00;
         6'd7:           byte_sel = 8'h01;
         [6'd12:6'd25]:  byte_sel = dqr_pkg::wire_name_byte(name_off[3:0]);
         [6'd26:6'd29]:  byte_sel = tc_bytes[tc_off[1:0]];
         6'd30:          byte_sel = 8'hC0;
         6'd31:          byte_sel = 8'h0C;
         6'd33, 6'd35:   byte_sel = 8'h01;
         [6'd36:6'd39]:  byte_sel = reply_ttl[8*(3-int'(ttl_off[1:0])) +: 8];
         6'd41:          byte_sel = 8'h04;
         [6'd42:6'd45]:  byte_sel = reply_address[8*(3-int'(addr_off[1:0])) +: 8];
         default:        byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      rpos_in      = rpos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (start) begin
         busy_in = 1'b1;
         rpos_in = '0;
      end else if (load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_byte      = byte_sel;
         rsp_data_in.last_of_reply = at_end;
         rpos_in                   = rpos_ff + 1'b1;
         if (at_end) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rpos_ff      <= rpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign busy      = busy_ff;

endmodule

FILE: rtl/dns_query_responder.sv
// top level of the dns query responder: a-record reply for one fixed host name
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | req_type: data_byte, last_of_datagram
//   rsp_    | out       | rsp_valid / rsp_stall | rsp_type: out_byte, last_of_reply
//   csr_    | in        | csr_valid / csr_ready | csr_index (1 bit), csr_data (32 bit)
//
// one request byte is taken per cycle while no reply is being sent
// the byte that completes the question class starts the reply walk;
// req_stall is held high for the whole walk, set by the reply busy flag, and
// stays high longer while rsp_stall holds a reply byte back
// a reply byte is offered in the cycle after it is selected and waits in the
// output register under rsp_stall; the walk pauses with it
// reset (synchronous, active high) returns parsing to the header, clears the
// reply walk and restores the ttl and address registers
module dns_query_responder (
   input  logic              clock,
   input  logic              reset,

   // request bytes
   input  logic              req_valid,
   output logic              req_stall,
   input  dqr_pkg::req_type  req_data,

   // reply bytes
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqr_pkg::rsp_type  rsp_data,

   // configuration writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);

   logic                   req_accept;
   logic                   reply_start;
   logic                   reply_busy;
   dqr_pkg::hdr_bytes_type hdr_bytes;
   dqr_pkg::tc_bytes_type  tc_bytes;

   logic [31:0]            reply_address_ff, reply_address_in;
   logic [31:0]            reply_ttl_ff, reply_ttl_in;

   // no request is taken while the reply walk reads the stores
   assign req_stall  = reply_busy;
   assign req_accept = req_valid && !req_stall;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      reply_address_in = reply_address_ff;
      reply_ttl_in     = reply_ttl_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dqr_pkg::CSR_REPLY_ADDRESS: reply_address_in = csr_data;
            dqr_pkg::CSR_REPLY_TTL:     reply_ttl_in     = csr_data;
            default:                    reply_ttl_in     = reply_ttl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_address_ff <= dqr_pkg::REPLY_ADDRESS_RESET;
         reply_ttl_ff     <= dqr_pkg::REPLY_TTL_RESET;
      end else begin
         reply_address_ff <= reply_address_in;
         reply_ttl_ff     <= reply_ttl_in;
      end
   end

   // header, name and type/class parsing
   dqr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req_data  (req_data),
      .hdr_bytes (hdr_bytes),
      .tc_bytes  (tc_bytes),
      .start     (reply_start)
   );

   // reply byte sequencing and output register
   dqr_reply_gen u_reply_gen (
      .clock         (clock),
      .reset         (reset),
      .start         (reply_start),
      .hdr_bytes     (hdr_bytes),
      .tc_bytes      (tc_bytes),
      .reply_ttl     (reply_ttl_ff),
      .reply_address (reply_address_ff),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .busy          (reply_busy)
   );

endmodule
